// File: rtl/coq_pkg.sv
// ----------------------------------------------------------------------------
// coq_pkg
// Shared types and constants for the circle obstacle table query block.
// ----------------------------------------------------------------------------
package coq_pkg;

  // defaults for the top-level parameters
  localparam int MAX_OBSTACLES_DEF = 64;
  localparam int COORD_BITS_DEF    = 20;

  // fixed field widths
  localparam int RAD_W    = 16;
  localparam int HGT_W    = 20;
  localparam int THR_W    = 3;
  localparam int OPC_W    = 2;
  localparam int CFG_W    = 20;
  localparam int OUT_TDATA_W = 24;

  localparam logic [RAD_W-1:0] VAULT_CLEARANCE     = 16'd50;
  localparam logic [RAD_W-1:0] DEFAULT_RADIUS_RST  = 16'd250;
  localparam logic [HGT_W-1:0] VAULT_THRESHOLD_RST = 20'd80;
  localparam logic [THR_W-1:0] THREAT_MAX          = 3'd4;

  // configuration register indexes
  localparam logic REG_DEFAULT_RADIUS  = 1'b0;
  localparam logic REG_VAULT_THRESHOLD = 1'b1;

  typedef enum logic [OPC_W-1:0] {
    OP_INSERT = 2'd0,
    OP_QUERY  = 2'd1,
    OP_VAULT  = 2'd2
  } opcode_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DRAIN
  } state_t;

  typedef struct packed {
    logic             table_full;
    logic [THR_W-1:0] threat;
    logic [RAD_W-1:0] eff_radius;
    logic             needs_vault;
    logic             obstructed;
  } result_t;

  // status from the distance compare pipeline
  typedef struct packed {
    logic hit;   // an in-range obstacle matched, one pulse per match
    logic busy;  // something still in flight
  } dist_stat_t;

endpackage

// File: rtl/coq_cell.sv
// ----------------------------------------------------------------------------
// coq_cell
// One table entry of the obstacle chain: centre and radius, loaded from the
// previous cell (or, for cell 0, the chain head) whenever the chain shifts.
// ----------------------------------------------------------------------------
module coq_cell #(
  parameter int COORD_BITS = coq_pkg::COORD_BITS_DEF
) (
  input  logic                         clk,
  input  logic                         shift,
  input  logic [COORD_BITS-1:0]        prev_x,
  input  logic [COORD_BITS-1:0]        prev_y,
  input  logic [coq_pkg::RAD_W-1:0]    prev_r,
  output logic [COORD_BITS-1:0]        x,
  output logic [COORD_BITS-1:0]        y,
  output logic [coq_pkg::RAD_W-1:0]    rad
);
  import coq_pkg::*;

  always_ff @(posedge clk) begin
    if (shift) begin
      x   <= prev_x;
      y   <= prev_y;
      rad <= prev_r;
    end
  end

endmodule

// File: rtl/coq_dist.sv
// ----------------------------------------------------------------------------
// coq_dist
// Three-stage squared distance compare: |d| and enlarged radius, squares,
// then sum and compare. One obstacle enters per cycle.
// ----------------------------------------------------------------------------
module coq_dist #(
  parameter int COORD_BITS = coq_pkg::COORD_BITS_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         valid,
  input  logic [COORD_BITS-1:0]        qx,
  input  logic [COORD_BITS-1:0]        qy,
  input  logic [COORD_BITS-1:0]        ox,
  input  logic [COORD_BITS-1:0]        oy,
  input  logic [coq_pkg::RAD_W-1:0]    orad,
  input  logic [coq_pkg::RAD_W-1:0]    clr,
  output coq_pkg::dist_stat_t          stat
);
  import coq_pkg::*;

  localparam int DW    = COORD_BITS + 1;
  localparam int SQ_W  = 2 * COORD_BITS;
  localparam int RS_W  = RAD_W + 1;
  localparam int RR_W  = 2 * RS_W;
  localparam int CMP_W = (SQ_W + 1 > RR_W) ? SQ_W + 1 : RR_W;

  logic signed [DW-1:0]     dx, dy;
  logic [COORD_BITS-1:0]    adx, ady;

  logic                     valid1;
  logic [COORD_BITS-1:0]    ax1, ay1;
  logic [RS_W-1:0]          rs1;

  logic                     valid2;
  logic [SQ_W-1:0]          sqx2, sqy2;
  logic [RR_W-1:0]          rr2;

  logic                     hit3;
  logic [CMP_W-1:0]         d2;

  always_comb begin
    dx  = $signed({qx[COORD_BITS-1], qx}) - $signed({ox[COORD_BITS-1], ox});
    dy  = $signed({qy[COORD_BITS-1], qy}) - $signed({oy[COORD_BITS-1], oy});
    adx = dx[DW-1] ? COORD_BITS'(-dx) : COORD_BITS'(dx);
    ady = dy[DW-1] ? COORD_BITS'(-dy) : COORD_BITS'(dy);
    d2  = CMP_W'(sqx2) + CMP_W'(sqy2);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid1 <= 1'b0;
      valid2 <= 1'b0;
      hit3   <= 1'b0;
    end else begin
      valid1 <= valid;
      valid2 <= valid1;
      hit3   <= valid2 && (d2 <= CMP_W'(rr2));
    end
  end

  always_ff @(posedge clk) begin
    ax1  <= adx;
    ay1  <= ady;
    rs1  <= RS_W'(orad) + RS_W'(clr);
    sqx2 <= SQ_W'(ax1) * SQ_W'(ax1);
    sqy2 <= SQ_W'(ay1) * SQ_W'(ay1);
    rr2  <= RR_W'(rs1) * RR_W'(rs1);
  end

  assign stat.hit  = hit3;
  assign stat.busy = valid1 | valid2 | hit3;

endmodule

// File: rtl/circle_obstacle_table_query_top.sv
// ----------------------------------------------------------------------------
// circle_obstacle_table_query_top
// Table of circular obstacles held in a shifting chain of cells, with point
// and midpoint collision queries against it.
// ----------------------------------------------------------------------------
//
// Channel | Dir | Handshake        | Payload
// --------+-----+------------------+------------------------------------------
// s       | in  | s_tvalid/tready  | tuser: opcode; tdata: point, radius, etc.
// m       | out | m_tvalid/tready  | tdata: obstructed .. table_full
// cfg     | in  | cfg_we           | cfg_index, cfg_data (no read-back)
//
// Insert and the unused opcode load the result register at the transfer.
// Query and vault check rotate the whole chain once, feeding the chain's end
// into a 3-stage compare pipeline, and load the result once it has drained.
// m_tvalid rises once the result has moved on to the output register. One
// item at a time: s_tready returns once the result has moved on to the output
// register. Reset (rst, synchronous) empties the table by zeroing the count;
// no clearing pass. A finished result sits in a result register and an output
// register, so one more item can be taken while the output is stalled.
//
module circle_obstacle_table_query_top #(
  parameter int MAX_OBSTACLES = coq_pkg::MAX_OBSTACLES_DEF,
  parameter int COORD_BITS    = coq_pkg::COORD_BITS_DEF
) (
  input  logic                                       clk,
  input  logic                                       rst,
  // slave side
  input  logic                                       s_tvalid,
  output logic                                       s_tready,
  // from bit 0: pos_x, pos_y, end_x, end_y, radius, height, clearance, zero pad
  input  logic [((4*COORD_BITS+52+7)/8)*8-1:0]       s_tdata,
  // opcode
  input  logic [coq_pkg::OPC_W-1:0]                  s_tuser,
  // master side
  output logic                                       m_tvalid,
  input  logic                                       m_tready,
  // from bit 0: obstructed, needs_vault, effective_radius, threat_level,
  // table_full, zero pad
  output logic [coq_pkg::OUT_TDATA_W-1:0]            m_tdata,
  // configuration
  input  logic                                       cfg_we,
  input  logic                                       cfg_index,
  input  logic [coq_pkg::CFG_W-1:0]                  cfg_data
);
  import coq_pkg::*;

  localparam int C     = COORD_BITS;
  localparam int N     = MAX_OBSTACLES;
  localparam int CW    = $clog2(N + 1);
  localparam int KW    = (N > 1) ? $clog2(N) : 1;
  localparam int ZW    = CW + 1;
  localparam int RES_W = $bits(result_t);

  // input field offsets within s_tdata
  localparam int OFF_PX  = 0;
  localparam int OFF_PY  = C;
  localparam int OFF_EX  = 2 * C;
  localparam int OFF_EY  = 3 * C;
  localparam int OFF_RAD = 4 * C;
  localparam int OFF_HGT = 4 * C + RAD_W;
  localparam int OFF_CLR = 4 * C + RAD_W + HGT_W;

  // unpacked input fields
  opcode_t          op;
  logic [C-1:0]     pos_x, pos_y, end_x, end_y;
  logic [RAD_W-1:0] radius, clearance;
  logic [HGT_W-1:0] height;

  assign op        = opcode_t'(s_tuser);
  assign pos_x     = s_tdata[OFF_PX  +: C];
  assign pos_y     = s_tdata[OFF_PY  +: C];
  assign end_x     = s_tdata[OFF_EX  +: C];
  assign end_y     = s_tdata[OFF_EY  +: C];
  assign radius    = s_tdata[OFF_RAD +: RAD_W];
  assign height    = s_tdata[OFF_HGT +: HGT_W];
  assign clearance = s_tdata[OFF_CLR +: RAD_W];

  // config registers
  logic [RAD_W-1:0] default_radius;
  logic [HGT_W-1:0] vault_thr;

  // control state
  state_t           state, state_next;
  logic [CW-1:0]    count;
  logic [THR_W-1:0] threat;
  logic [KW-1:0]    k;
  logic             acc;
  logic             res_valid;
  logic             out_valid;

  // held query
  logic [C-1:0]     qx, qy;
  logic [RAD_W-1:0] clr;
  result_t          res, res_next, out_res;

  logic             in_accept;
  logic             has_room;
  logic [THR_W-1:0] threat_inc;
  logic [RAD_W-1:0] eff_rad;
  logic signed [C:0] sum_x, sum_y;
  logic [C-1:0]     mid_x, mid_y;
  logic             res_load, insert_go, scan_go;
  logic             res_move;
  logic             shift;
  logic             feed_valid;
  dist_stat_t       stat;

  // chain taps
  logic [C-1:0]     cx [N];
  logic [C-1:0]     cy [N];
  logic [RAD_W-1:0] cr [N];
  logic [C-1:0]     head_x, head_y;
  logic [RAD_W-1:0] head_r;

  assign s_tready   = (state == ST_IDLE) && !res_valid;
  assign in_accept  = s_tvalid && s_tready;
  assign has_room   = count < CW'(N);
  assign threat_inc = (threat < THREAT_MAX) ? threat + 3'd1 : threat;
  assign eff_rad    = (radius != '0) ? radius : default_radius;

  // floor midpoint: arithmetic halving of the widened sum
  assign sum_x = $signed({pos_x[C-1], pos_x}) + $signed({end_x[C-1], end_x});
  assign sum_y = $signed({pos_y[C-1], pos_y}) + $signed({end_y[C-1], end_y});
  assign mid_x = sum_x[C:1];
  assign mid_y = sum_y[C:1];

  // entries sit in cells 0..count-1; during the rotation step k the chain's
  // end holds the entry that started in cell N-1-k
  assign feed_valid = (state == ST_SCAN) && ((ZW'(k) + ZW'(count)) >= ZW'(N));

  always_comb begin
    state_next = state;
    res_load   = 1'b0;
    insert_go  = 1'b0;
    scan_go    = 1'b0;
    res_next   = '0;
    res_next.threat = threat;
    unique case (state)
      ST_IDLE: begin
        if (in_accept) begin
          unique case (op)
            OP_INSERT: begin
              insert_go              = 1'b1;
              res_load               = 1'b1;
              res_next.eff_radius    = eff_rad;
              res_next.table_full    = !has_room;
              res_next.threat        = threat_inc;
              res_next.needs_vault   = $signed(height) >= $signed(vault_thr);
            end
            OP_QUERY, OP_VAULT: begin
              scan_go    = 1'b1;
              state_next = ST_SCAN;
            end
            default: begin
              res_load = 1'b1;
            end
          endcase
        end
      end
      ST_SCAN: begin
        if (k == KW'(N - 1)) begin
          state_next = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        // pipeline empty: every hit has reached acc
        if (!stat.busy) begin
          res_load            = 1'b1;
          res_next.obstructed = acc;
          state_next          = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  assign res_move = res_valid && (!out_valid || m_tready);

  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= ST_IDLE;
      count          <= '0;
      threat         <= '0;
      res_valid      <= 1'b0;
      out_valid      <= 1'b0;
      default_radius <= DEFAULT_RADIUS_RST;
      vault_thr      <= VAULT_THRESHOLD_RST;
    end else begin
      state <= state_next;
      if (cfg_we) begin
        unique case (cfg_index)
          REG_DEFAULT_RADIUS:  default_radius <= cfg_data[RAD_W-1:0];
          REG_VAULT_THRESHOLD: vault_thr      <= cfg_data[HGT_W-1:0];
          default: ;
        endcase
      end
      if (insert_go) begin
        threat <= threat_inc;
        if (has_room) begin
          count <= count + CW'(1);
        end
      end
      if (res_load) begin
        res_valid <= 1'b1;
      end else if (res_move) begin
        res_valid <= 1'b0;
      end
      if (res_move) begin
        out_valid <= 1'b1;
      end else if (m_tready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // payload and scan bookkeeping
  always_ff @(posedge clk) begin
    if (scan_go) begin
      qx  <= (op == OP_VAULT) ? mid_x : pos_x;
      qy  <= (op == OP_VAULT) ? mid_y : pos_y;
      clr <= (op == OP_VAULT) ? VAULT_CLEARANCE : clearance;
      k   <= '0;
      acc <= 1'b0;
    end else begin
      if (state == ST_SCAN) begin
        k <= k + KW'(1);
      end
      acc <= acc | stat.hit;
    end
    if (res_load) begin
      res <= res_next;
    end
    if (res_move) begin
      out_res <= res;
    end
  end

  // obstacle chain: inserts push in at cell 0, a scan rotates the ring once
  assign shift  = (insert_go && has_room) || (state == ST_SCAN);
  assign head_x = (state == ST_SCAN) ? cx[N-1] : pos_x;
  assign head_y = (state == ST_SCAN) ? cy[N-1] : pos_y;
  assign head_r = (state == ST_SCAN) ? cr[N-1] : eff_rad;

  generate
    for (genvar i = 0; i < N; i++) begin : g_cell
      if (i == 0) begin : g_first
        coq_cell #(.COORD_BITS(C)) u_cell (
          .clk   (clk),
          .shift (shift),
          .prev_x(head_x),
          .prev_y(head_y),
          .prev_r(head_r),
          .x     (cx[i]),
          .y     (cy[i]),
          .rad   (cr[i])
        );
      end else begin : g_rest
        coq_cell #(.COORD_BITS(C)) u_cell (
          .clk   (clk),
          .shift (shift),
          .prev_x(cx[i-1]),
          .prev_y(cy[i-1]),
          .prev_r(cr[i-1]),
          .x     (cx[i]),
          .y     (cy[i]),
          .rad   (cr[i])
        );
      end
    end
  endgenerate

  coq_dist #(.COORD_BITS(C)) u_dist (
    .clk  (clk),
    .rst  (rst),
    .valid(feed_valid),
    .qx   (qx),
    .qy   (qy),
    .ox   (cx[N-1]),
    .oy   (cy[N-1]),
    .orad (cr[N-1]),
    .clr  (clr),
    .stat (stat)
  );

  assign m_tvalid = out_valid;
  assign m_tdata  = {(OUT_TDATA_W - RES_W)'(0), out_res};

endmodule

// File: tb/tb_circle_obstacle_table_query_top.sv
// ----------------------------------------------------------------------------
// tb_circle_obstacle_table_query_top
// Self-checking bench for the circle obstacle table. A directed table covers
// empty-table queries, reset register values, boundary hits, floor rounding
// of the vault midpoint, zero and maximum default radius and the threshold
// extremes. Random phases then fill the table past its capacity, aim queries
// and vault checks at stored circles, and check every result transfer
// against an in-bench predictor, with bursty input and a stalling output.
// ----------------------------------------------------------------------------
module tb_circle_obstacle_table_query_top;
  timeunit 1ns;
  timeprecision 1ps;

  import coq_pkg::*;

  localparam int NOBS    = MAX_OBSTACLES_DEF;
  localparam int CW      = COORD_BITS_DEF;
  localparam int TDATA_W = ((4*CW+52+7)/8)*8;

  // opcode 3 is not in the package enum; the block must treat it as a no-op
  localparam logic [OPC_W-1:0] OP_UNUSED = 2'd3;

  localparam int COORD_MAX = 524287;
  localparam int COORD_MIN = -524288;

  localparam int SETTLE_CYCLES = 8;          // idle time before a register write
  localparam int END_CYCLES    = NOBS + 8;   // one full scan plus drain
  localparam int HOLD_CYCLES   = 700;        // long output back-pressure
  localparam int WATCHDOG      = 4000;       // cycles with no transfer at all
  localparam int N_PHASES      = 6;
  localparam int PHASE_ITEMS   = 100;

  typedef struct {
    logic [OPC_W-1:0]       op;
    logic signed [CW-1:0]   px;
    logic signed [CW-1:0]   py;
    logic signed [CW-1:0]   ex;
    logic signed [CW-1:0]   ey;
    logic [RAD_W-1:0]       rad;
    logic signed [HGT_W-1:0] hgt;
    logic [RAD_W-1:0]       clr;
  } obst_item_t;

  // one row of the directed table: either a register setting or an item
  typedef struct {
    bit               is_cfg;
    logic [RAD_W-1:0] dr;
    logic [HGT_W-1:0] thr;
    obst_item_t       it;
    bit               typed;   // want holds a hand-written answer
    result_t          want;
  } drow_t;

  logic clk;
  logic rst = 1'b1;

  logic                 s_tvalid = 1'b0;
  logic                 s_tready;
  // from bit 0: pos_x, pos_y, end_x, end_y, radius, height, clearance, zero pad
  logic [TDATA_W-1:0]   s_tdata  = '0;
  // opcode
  logic [OPC_W-1:0]     s_tuser  = '0;
  logic                 m_tvalid;
  logic                 m_tready = 1'b0;
  // from bit 0: obstructed, needs_vault, effective_radius, threat_level,
  // table_full, zero pad
  logic [OUT_TDATA_W-1:0] m_tdata;
  logic                 cfg_we    = 1'b0;
  logic                 cfg_index = 1'b0;
  logic [CFG_W-1:0]     cfg_data  = '0;

  circle_obstacle_table_query_top i_dut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // --------------------------------------------------------------------------
  // Predictor state: the obstacle table, threat count and registers as the
  // block should hold them after every accepted transfer.
  // --------------------------------------------------------------------------
  logic signed [CW-1:0]    obs_x [NOBS];
  logic signed [CW-1:0]    obs_y [NOBS];
  logic [RAD_W-1:0]        obs_r [NOBS];
  int                      n_stored    = 0;
  logic [THR_W-1:0]        threat_q    = '0;
  logic [RAD_W-1:0]        dflt_radius = DEFAULT_RADIUS_RST;
  logic signed [HGT_W-1:0] vault_thr   = VAULT_THRESHOLD_RST;

  result_t answers_due [$];   // answers for accepted items, oldest first

  int errors    = 0;
  int n_sent    = 0;
  int n_checked = 0;
  int n_insert  = 0;
  int n_drop    = 0;
  int n_query   = 0;
  int n_vault   = 0;
  int n_unused  = 0;
  int n_hit     = 0;
  int quiet     = 0;

  // exact squared-distance test against every stored circle
  function automatic bit covered_by_any(longint px, longint py, longint clr);
    longint dx, dy, rr;
    for (int i = 0; i < n_stored; i++) begin
      dx = px - longint'(obs_x[i]);
      dy = py - longint'(obs_y[i]);
      rr = longint'(obs_r[i]) + clr;
      if (dx*dx + dy*dy <= rr*rr) return 1'b1;
    end
    return 1'b0;
  endfunction

  // answer for one item; updates table and threat as the block would
  function automatic result_t table_answer(obst_item_t it);
    result_t          a;
    logic [RAD_W-1:0] eff;
    longint           mx, my;
    a = '0;
    case (it.op)
      OP_INSERT: begin
        eff          = (it.rad != '0) ? it.rad : dflt_radius;
        a.eff_radius = eff;
        if (n_stored < NOBS) begin
          obs_x[n_stored] = it.px;
          obs_y[n_stored] = it.py;
          obs_r[n_stored] = eff;
          n_stored++;
        end else begin
          a.table_full = 1'b1;
        end
        if (threat_q < THREAT_MAX) threat_q++;
        a.needs_vault = (it.hgt >= vault_thr);
      end
      OP_QUERY: begin
        a.obstructed = covered_by_any(longint'(it.px), longint'(it.py), longint'(it.clr));
      end
      OP_VAULT: begin
        // arithmetic shift floors, also for negative sums
        mx = (longint'(it.px) + longint'(it.ex)) >>> 1;
        my = (longint'(it.py) + longint'(it.ey)) >>> 1;
        a.obstructed = covered_by_any(mx, my, longint'(VAULT_CLEARANCE));
      end
      default: ;
    endcase
    a.threat = threat_q;
    return a;
  endfunction

  function automatic result_t ans(bit obs, bit vault, int eff, int thr, bit full);
    result_t a;
    a.obstructed  = obs;
    a.needs_vault = vault;
    a.eff_radius  = eff[RAD_W-1:0];
    a.threat      = thr[THR_W-1:0];
    a.table_full  = full;
    return a;
  endfunction

  function automatic drow_t item_row(logic [OPC_W-1:0] op, int px, int py, int ex, int ey,
                                     int rad, int hgt, int clr, bit typed, result_t want);
    drow_t r;
    r.is_cfg = 1'b0;
    r.dr     = '0;
    r.thr    = '0;
    r.it.op  = op;
    r.it.px  = px[CW-1:0];
    r.it.py  = py[CW-1:0];
    r.it.ex  = ex[CW-1:0];
    r.it.ey  = ey[CW-1:0];
    r.it.rad = rad[RAD_W-1:0];
    r.it.hgt = hgt[HGT_W-1:0];
    r.it.clr = clr[RAD_W-1:0];
    r.typed  = typed;
    r.want   = want;
    return r;
  endfunction

  function automatic drow_t cfg_row(int dr, int thr);
    drow_t r;
    r        = item_row(OP_UNUSED, 0, 0, 0, 0, 0, 0, 0, 1'b0, '0);
    r.is_cfg = 1'b1;
    r.dr     = dr[RAD_W-1:0];
    r.thr    = thr[HGT_W-1:0];
    return r;
  endfunction

  function automatic logic [31:0] rnd32();
    return $urandom();
  endfunction

  // random signed offset in [-span, span]
  function automatic longint spread(longint span);
    return longint'($urandom_range(0, 32'(2*span))) - span;
  endfunction

  // point near the boundary of a circle of total reach rt around (cx, cy)
  function automatic void near_edge(longint cx, longint cy, longint rt,
                                    output longint x, output longint y);
    longint dx, dy;
    case ($urandom_range(0, 3))
      0:       begin dx = rt;     dy = 0; end   // exactly on the edge
      1:       begin dx = rt + 1; dy = 0; end   // one unit outside
      default: begin dx = spread(rt + 3); dy = spread(rt + 3); end
    endcase
    if ($urandom_range(0, 1) == 1) begin
      x = dy; dy = dx; dx = x;
    end
    if ($urandom_range(0, 1) == 1) dx = -dx;
    if ($urandom_range(0, 1) == 1) dy = -dy;
    x = cx + dx;
    y = cy + dy;
  endfunction

  // random item, mostly aimed at stored circles so hits and misses both occur
  function automatic obst_item_t next_random_item();
    obst_item_t  it;
    logic [31:0] r;
    longint      tx, ty, d, v;
    int          pick, i;
    r = rnd32(); it.px  = r[CW-1:0];
    r = rnd32(); it.py  = r[CW-1:0];
    r = rnd32(); it.ex  = r[CW-1:0];
    r = rnd32(); it.ey  = r[CW-1:0];
    r = rnd32(); it.rad = r[RAD_W-1:0];
    r = rnd32(); it.hgt = r[HGT_W-1:0];
    r = rnd32(); it.clr = r[RAD_W-1:0];
    pick = $urandom_range(0, 99);
    if (pick < 13) begin
      it.op = OP_INSERT;
      if ($urandom_range(0, 1) == 1) begin
        // cluster near the origin so circles overlap
        v = spread(20000); it.px = v[CW-1:0];
        v = spread(20000); it.py = v[CW-1:0];
      end
      pick = $urandom_range(0, 19);
      if (pick < 2)       it.rad = '0;
      else if (pick == 2) it.rad = '1;
      else if (pick < 15) it.rad = RAD_W'($urandom_range(1, 3000));
      if ($urandom_range(0, 2) == 0) begin
        v = longint'(vault_thr) + spread(2);
        it.hgt = v[HGT_W-1:0];
      end
    end else if (pick < 92) begin
      it.op = (pick < 55) ? OP_QUERY : OP_VAULT;
      if (it.op == OP_QUERY) begin
        pick = $urandom_range(0, 9);
        if (pick < 6)       it.clr = RAD_W'($urandom_range(0, 200));
        else if (pick == 6) it.clr = '1;
      end
      if (n_stored != 0 && $urandom_range(0, 4) != 0) begin
        i = $urandom_range(0, n_stored - 1);
        near_edge(longint'(obs_x[i]), longint'(obs_y[i]),
                  longint'(obs_r[i]) +
                  ((it.op == OP_QUERY) ? longint'(it.clr) : longint'(VAULT_CLEARANCE)),
                  tx, ty);
        if (it.op == OP_QUERY) begin
          it.px = tx[CW-1:0];
          it.py = ty[CW-1:0];
        end else begin
          // endpoints placed so the floored midpoint lands on (tx, ty)
          d = ($urandom_range(0, 1) == 1) ? spread(1000) : spread(200000);
          v = tx + d;                                     it.px = v[CW-1:0];
          v = 2*tx - v + longint'($urandom_range(0, 1));  it.ex = v[CW-1:0];
          d = ($urandom_range(0, 1) == 1) ? spread(1000) : spread(200000);
          v = ty + d;                                     it.py = v[CW-1:0];
          v = 2*ty - v + longint'($urandom_range(0, 1));  it.ey = v[CW-1:0];
        end
      end
    end else begin
      it.op = OP_UNUSED;
    end
    return it;
  endfunction

  // present one item and hold it until the transfer happens;
  // called just after a rising edge
  task automatic offer(input obst_item_t it, input bit typed, input result_t want);
    result_t a;
    s_tvalid <= 1'b1;
    s_tuser  <= it.op;
    s_tdata  <= TDATA_W'({it.clr, it.hgt, it.rad, it.ey, it.ex, it.py, it.px});
    do @(posedge clk); while (!s_tready);
    a = table_answer(it);
    answers_due.push_back(typed ? want : a);
    n_sent++;
    case (it.op)
      OP_INSERT: begin n_insert++; if (a.table_full) n_drop++; end
      OP_QUERY:  n_query++;
      OP_VAULT:  n_vault++;
      default:   n_unused++;
    endcase
    if (a.obstructed) n_hit++;
  endtask

  // stop sending and wait until every answer has been seen
  task automatic settle(input int tail);
    s_tvalid <= 1'b0;
    do @(posedge clk); while (answers_due.size() != 0);
    repeat (tail) @(posedge clk);
  endtask

  task automatic program_regs(input logic [RAD_W-1:0] dr, input logic [HGT_W-1:0] thr);
    cfg_we    <= 1'b1;
    cfg_index <= REG_DEFAULT_RADIUS;
    cfg_data  <= CFG_W'(dr);
    @(posedge clk);
    cfg_index <= REG_VAULT_THRESHOLD;
    cfg_data  <= thr;
    @(posedge clk);
    cfg_we      <= 1'b0;
    dflt_radius  = dr;
    vault_thr    = thr;
  endtask

  // --------------------------------------------------------------------------
  // Stimulus
  // --------------------------------------------------------------------------
  initial begin
    drow_t            dir_rows [$];
    obst_item_t       it;
    logic [31:0]      r;
    logic [RAD_W-1:0] dr;
    logic [HGT_W-1:0] thr;
    int               gap, burst, sent_ph;

    // Directed table. Registers start at reset values (radius 250, threshold 80).
    // empty table: nothing can be hit
    dir_rows.push_back(item_row(OP_QUERY, 0, 0, -1, -1, 65535, -1, 65535,
                                1'b1, ans(0, 0, 0, 0, 0)));
    dir_rows.push_back(item_row(OP_VAULT, COORD_MAX, COORD_MIN, COORD_MIN, COORD_MAX,
                                0, 0, 0, 1'b1, ans(0, 0, 0, 0, 0)));
    // unused opcode with every field set: no effect
    dir_rows.push_back(item_row(OP_UNUSED, -1, -1, -1, -1, 65535, -1, 65535,
                                1'b1, ans(0, 0, 0, 0, 0)));
    // zero radius takes the reset default; height at threshold needs a vault
    dir_rows.push_back(item_row(OP_INSERT, 0, 0, 0, 0, 0, 80, 0,
                                1'b1, ans(0, 1, 250, 1, 0)));
    dir_rows.push_back(item_row(OP_INSERT, COORD_MAX, COORD_MAX, 0, 0, 65535, 79, 0,
                                1'b1, ans(0, 0, 65535, 2, 0)));
    dir_rows.push_back(item_row(OP_INSERT, -500, 0, 0, 0, 1, COORD_MIN, 0,
                                1'b1, ans(0, 0, 1, 3, 0)));
    // 150^2 + 200^2 = 250^2: on the edge, then just off it
    dir_rows.push_back(item_row(OP_QUERY, 150, 200, 0, 0, 0, 0, 0, 1'b0, '0));
    dir_rows.push_back(item_row(OP_QUERY, 151, 200, 0, 0, 0, 0, 0, 1'b0, '0));
    dir_rows.push_back(item_row(OP_QUERY, 300, 0, 0, 0, 0, 0, 50, 1'b0, '0));
    // negative odd sums: floor gives -552 (miss) and -551 (hit) near (-500,0)
    dir_rows.push_back(item_row(OP_VAULT, -1103, 0, 0, 0, 0, 0, 0, 1'b0, '0));
    dir_rows.push_back(item_row(OP_VAULT, -1101, 0, 0, 0, 0, 0, 0, 1'b0, '0));
    dir_rows.push_back(item_row(OP_VAULT, COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX,
                                0, 0, 0, 1'b0, '0));
    dir_rows.push_back(item_row(OP_VAULT, COORD_MIN, COORD_MIN, COORD_MIN, COORD_MIN,
                                0, 0, 0, 1'b0, '0));
    dir_rows.push_back(item_row(OP_QUERY, COORD_MIN, COORD_MIN, 0, 0, 0, 0, 65535,
                                1'b0, '0));
    // zero default radius, lowest threshold: every height needs a vault
    dir_rows.push_back(cfg_row(0, COORD_MIN));
    dir_rows.push_back(item_row(OP_INSERT, 1000, 1000, 0, 0, 0, COORD_MIN, 0,
                                1'b1, ans(0, 1, 0, 4, 0)));
    // threat already saturated
    dir_rows.push_back(item_row(OP_INSERT, 2000, 2000, 0, 0, 5, COORD_MAX, 0,
                                1'b1, ans(0, 1, 5, 4, 0)));
    dir_rows.push_back(item_row(OP_QUERY, 1000, 1000, 0, 0, 0, 0, 0, 1'b0, '0));
    dir_rows.push_back(item_row(OP_QUERY, 1001, 1000, 0, 0, 0, 0, 0, 1'b0, '0));
    // largest default radius, highest threshold
    dir_rows.push_back(cfg_row(65535, COORD_MAX));
    dir_rows.push_back(item_row(OP_INSERT, -2000, 3000, 0, 0, 0, COORD_MAX, 0,
                                1'b1, ans(0, 1, 65535, 4, 0)));
    dir_rows.push_back(item_row(OP_INSERT, 7, -7, 0, 0, 7, COORD_MAX - 1, 0,
                                1'b1, ans(0, 0, 7, 4, 0)));
    dir_rows.push_back(item_row(OP_UNUSED, 0, 0, 0, 0, 0, 0, 0,
                                1'b1, ans(0, 0, 0, 4, 0)));
    // widest reach: radius 65535 plus clearance 65535, on the edge
    dir_rows.push_back(item_row(OP_QUERY, 129070, 3000, 0, 0, 0, 0, 65535, 1'b0, '0));

    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (dir_rows[i]) begin
      if (dir_rows[i].is_cfg) begin
        settle(SETTLE_CYCLES);
        program_regs(dir_rows[i].dr, dir_rows[i].thr);
      end else begin
        offer(dir_rows[i].it, dir_rows[i].typed, dir_rows[i].want);
        gap = $urandom_range(0, 3);
        if (gap != 0) begin
          s_tvalid <= 1'b0;
          repeat (gap) @(posedge clk);
        end
      end
    end

    // Random phases, each under its own register setting written while idle.
    for (int ph = 0; ph < N_PHASES; ph++) begin
      settle(SETTLE_CYCLES);
      case (ph)
        0:       begin dr = DEFAULT_RADIUS_RST; thr = VAULT_THRESHOLD_RST; end
        1:       begin dr = '0; thr = HGT_W'(COORD_MIN); end
        2:       begin dr = '1; thr = HGT_W'(COORD_MAX); end
        4:       begin dr = RAD_W'($urandom_range(1, 3000)); thr = '0; end
        default: begin r = rnd32(); dr = r[RAD_W-1:0]; r = rnd32(); thr = r[HGT_W-1:0]; end
      endcase
      program_regs(dr, thr);
      sent_ph = 0;
      while (sent_ph < PHASE_ITEMS) begin
        burst = $urandom_range(1, 24);
        for (int k = 0; k < burst && sent_ph < PHASE_ITEMS; k++) begin
          it = next_random_item();
          offer(it, 1'b0, '0);
          sent_ph++;
        end
        gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
        if (gap != 0) begin
          s_tvalid <= 1'b0;
          repeat (gap) @(posedge clk);
        end
      end
    end

    settle(END_CYCLES);

    $display("Sent %0d items: %0d inserts (%0d dropped on a full table), %0d queries,",
             n_sent, n_insert, n_drop, n_query);
    $display("%0d vault checks, %0d unused opcodes; %0d results checked, %0d obstructed.",
             n_vault, n_unused, n_checked, n_hit);
    if (errors == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  // --------------------------------------------------------------------------
  // Output side: stall pattern of its own, plus one long hold-off while the
  // sender keeps offering so the block fills and drops s_tready.
  // --------------------------------------------------------------------------
  initial begin
    bit held;
    int mode, span;
    held = 1'b0;
    do @(posedge clk); while (rst);
    forever begin
      if (!held && n_sent >= 180) begin
        held = 1'b1;
        m_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else begin
        mode = $urandom_range(0, 2);
        span = $urandom_range(5, 60);
        repeat (span) begin
          case (mode)
            0:       m_tready <= 1'b1;
            1:       m_tready <= ($urandom_range(0, 1) == 1);
            default: m_tready <= ($urandom_range(0, 3) == 0);
          endcase
          @(posedge clk);
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Result check: each result transfer against the oldest pending answer.
  // --------------------------------------------------------------------------
  result_t got_ans, want_ans;

  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      if (answers_due.size() == 0) begin
        $error("result transfer with no item pending: m_tdata=%h", m_tdata);
        errors++;
      end else begin
        want_ans = answers_due.pop_front();
        got_ans  = result_t'(m_tdata[$bits(result_t)-1:0]);
        n_checked++;
        if (got_ans.obstructed !== want_ans.obstructed) begin
          $error("obstructed: expected %0d, got %0d", want_ans.obstructed, got_ans.obstructed);
          errors++;
        end
        if (got_ans.needs_vault !== want_ans.needs_vault) begin
          $error("needs_vault: expected %0d, got %0d",
                 want_ans.needs_vault, got_ans.needs_vault);
          errors++;
        end
        if (got_ans.eff_radius !== want_ans.eff_radius) begin
          $error("effective_radius: expected %0d, got %0d",
                 want_ans.eff_radius, got_ans.eff_radius);
          errors++;
        end
        if (got_ans.threat !== want_ans.threat) begin
          $error("threat_level: expected %0d, got %0d", want_ans.threat, got_ans.threat);
          errors++;
        end
        if (got_ans.table_full !== want_ans.table_full) begin
          $error("table_full: expected %0d, got %0d", want_ans.table_full, got_ans.table_full);
          errors++;
        end
      end
    end
  end

  // watchdog: too long without any transfer on either side
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      quiet <= 0;
    end else if (quiet >= WATCHDOG) begin
      $display("Timeout: no transfer for %0d cycles, %0d answers pending",
               quiet, answers_due.size());
      $display("Some tests failed");
      $finish;
    end else begin
      quiet <= quiet + 1;
    end
  end

endmodule

// File: sim.f
rtl/coq_pkg.sv
rtl/coq_cell.sv
rtl/coq_dist.sv
rtl/circle_obstacle_table_query_top.sv
tb/tb_circle_obstacle_table_query_top.sv
